### rtl/core/first_fit_block_allocator_macros.svh
// Assertion macros for the first-fit block allocator.
// Included by the RTL files that carry concurrent assertions.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define FFA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define FFA_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define FFA_ASSERT(lbl, clk, rst_n, prop)
`define FFA_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

### rtl/core/ffa_pkg.sv
// Shared types and codes for the first-fit block allocator.
// No dependencies.
`default_nettype none
package ffa_pkg;
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic {
        CFG_HEAP_BASE = 1'b0,
        CFG_HEAP_SIZE = 1'b1
    } cfg_index_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } state_t;

    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] size;
        logic        free;
        logic        valid;
    } seg_t;

    typedef struct packed {
        logic        init;
        logic [31:0] init_size;
        logic        launch;
        kind_t       kind;
        logic [31:0] req;
        logic [31:0] req_hdr;
        logic [31:0] base_hdr;
        logic [31:0] addr;
        logic        split_ok;
        logic        shift;
    } cmd_t;

    typedef struct packed {
        seg_t        seg;
        logic        tok;
        logic        ins;
        logic [31:0] ins_offset;
        logic [31:0] ins_size;
    } link_t;
endpackage
`default_nettype wire

### rtl/core/ffa_cell.sv
// One segment-table cell: holds one segment, checks it when the scan token arrives.
// Depends on ffa_pkg.
`default_nettype none
module ffa_cell #(
    parameter int          HEADER_BYTES = 32,
    parameter bit          IS_FIRST     = 1'b0,
    parameter logic [31:0] RST_SIZE     = 32'd0
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ffa_pkg::cmd_t cmd,
    input  wire ffa_pkg::link_t left,
    output ffa_pkg::link_t     right,
    output logic               hit,
    output logic               split,
    output logic [31:0]        res_addr
);
    localparam logic [31:0] HDR = 32'(HEADER_BYTES);

    ffa_pkg::seg_t seg_reg, seg_next;
    logic          tok_reg, tok_next;
    logic          seen_reg, seen_next;
    logic [31:0]   rem;
    logic [31:0]   payload;
    logic          fit;

    always_comb
    begin
        payload  = cmd.base_hdr + seg_reg.offset;
        rem      = seg_reg.size - cmd.req;
        fit      = seg_reg.valid && seg_reg.free && (seg_reg.size >= cmd.req);
        if (cmd.kind == ffa_pkg::KIND_FREE)
        begin
            hit = tok_reg && seg_reg.valid && (payload == cmd.addr);
        end
        else
        begin
            hit = tok_reg && fit;
        end
        split    = hit && (cmd.kind == ffa_pkg::KIND_ALLOC) && cmd.split_ok && (rem >= HDR);
        res_addr = (hit && cmd.kind == ffa_pkg::KIND_ALLOC) ? payload : 32'd0;

        right.seg        = seg_reg;
        right.tok        = tok_reg && !hit;
        right.ins        = split;
        right.ins_offset = seg_reg.offset + cmd.req_hdr;
        right.ins_size   = rem - HDR;

        seg_next  = seg_reg;
        tok_next  = cmd.launch ? IS_FIRST : left.tok;
        seen_next = cmd.launch ? 1'b0 : (seen_reg || tok_reg);
        if (cmd.init)
        begin
            tok_next  = 1'b0;
            seen_next = 1'b0;
            if (IS_FIRST)
            begin
                seg_next = '{offset: 32'd0, size: cmd.init_size, free: 1'b1, valid: 1'b1};
            end
            else
            begin
                seg_next = '0;
            end
        end
        else if (hit)
        begin
            if (cmd.kind == ffa_pkg::KIND_FREE)
            begin
                seg_next.free = 1'b1;
            end
            else
            begin
                seg_next.free = 1'b0;
                if (split)
                begin
                    seg_next.size = cmd.req;
                end
            end
        end
        else if (cmd.shift && !seen_reg && !tok_reg)
        begin
            if (left.ins)
            begin
                seg_next = '{offset: left.ins_offset, size: left.ins_size,
                             free: 1'b1, valid: 1'b1};
            end
            else
            begin
                seg_next = left.seg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg  <= IS_FIRST
                        ? ffa_pkg::seg_t'{offset: 32'd0, size: RST_SIZE, free: 1'b1, valid: 1'b1}
                        : ffa_pkg::seg_t'('0);
            tok_reg  <= 1'b0;
            seen_reg <= 1'b0;
        end
        else
        begin
            seg_reg  <= seg_next;
            tok_reg  <= tok_next;
            seen_reg <= seen_next;
        end
    end
endmodule
`default_nettype wire

### rtl/core/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: controller and the row of segment cells.
// Depends on ffa_pkg, ffa_cell and first_fit_block_allocator_macros.svh.
//
// Usage: raise start with kind, req_size and release_addr while busy is low; the
// command transfers at that edge and busy rises. A scan token walks the segment
// row one cell per cycle. On the first matching cell the result appears on
// status and payload_addr with done high for one cycle, and busy drops in that
// same cycle, so the next command may transfer then. An allocate that splits a
// segment shifts all later cells by one place in the hit cycle.
// A hit ends the scan at the first matching cell; out of memory or an unmatched
// free ends it when the token reaches the last cell without a match.
// Configuration: cfg_valid/cfg_ready write heap_base (index 0) or heap_size
// (index 1); either write rebuilds the table as one free segment at once.
// cfg_ready is high whenever busy and start are both low.
// Reset: heap_base 0, heap_size 65536, one free segment, no command in flight.
// The result receiver cannot stall; done is a one-cycle strobe.
`default_nettype none
`include "first_fit_block_allocator_macros.svh"
module first_fit_block_allocator #(
    parameter int MAX_SEGMENTS = 64,
    parameter int HEADER_BYTES = 32,
    parameter int MIN_ALLOC    = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        kind,
    input  wire logic [31:0] req_size,
    input  wire logic [31:0] release_addr,
    output logic             done,
    output logic [1:0]       status,
    output logic [31:0]      payload_addr,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam logic [31:0] HDR      = 32'(HEADER_BYTES);
    localparam logic [31:0] MINA     = 32'(MIN_ALLOC);
    localparam logic [32:0] RST_HEAP = 33'd65536;
    localparam logic [31:0] RST_SIZE = (RST_HEAP >= 33'(HEADER_BYTES))
                                       ? 32'(RST_HEAP - 33'(HEADER_BYTES)) : 32'd0;
    localparam int          CW       = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] MAXC   = CW'(MAX_SEGMENTS);

    ffa_pkg::state_t state_reg, state_next;
    logic [31:0]     base_reg, base_next;
    logic [31:0]     size_reg, size_next;
    logic [31:0]     base_hdr_reg, base_hdr_next;
    logic [CW-1:0]   count_reg, count_next;
    ffa_pkg::kind_t  kind_reg, kind_next;
    logic [31:0]     req_reg, req_next;
    logic [31:0]     req_hdr_reg, req_hdr_next;
    logic [31:0]     addr_reg, addr_next;
    logic            done_reg, done_next;
    logic [1:0]      status_reg, status_next;
    logic [31:0]     paddr_reg, paddr_next;

    ffa_pkg::cmd_t   cmd;
    ffa_pkg::link_t  links [MAX_SEGMENTS+1];
    logic [MAX_SEGMENTS-1:0] hits;
    logic [MAX_SEGMENTS-1:0] splits;
    logic [31:0]     res_addrs [MAX_SEGMENTS];
    logic [31:0]     res_or;
    logic            any_hit;
    logic            cfg_wr;
    logic            accept;
    logic [31:0]     raised;
    logic [31:0]     new_heap;

    assign busy         = (state_reg == ffa_pkg::S_SCAN);
    assign cfg_ready    = !busy && !start;
    assign cfg_wr       = cfg_valid && cfg_ready;
    assign accept       = start && !busy;
    assign done         = done_reg;
    assign status       = status_reg;
    assign payload_addr = paddr_reg;
    assign raised       = (req_size < MINA) ? MINA : req_size;
    assign new_heap     = (cfg_index == ffa_pkg::CFG_HEAP_SIZE) ? cfg_data : size_reg;
    assign links[0]     = '0;

    always_comb
    begin
        res_or = 32'd0;
        for (int i = 0; i < MAX_SEGMENTS; i++)
        begin
            res_or = res_or | res_addrs[i];
        end
        any_hit = |hits;

        cmd.init      = cfg_wr;
        cmd.init_size = (new_heap >= HDR) ? (new_heap - HDR) : 32'd0;
        cmd.launch    = accept;
        cmd.kind      = kind_reg;
        cmd.req       = req_reg;
        cmd.req_hdr   = req_hdr_reg;
        cmd.base_hdr  = base_hdr_reg;
        cmd.addr      = addr_reg;
        cmd.split_ok  = (count_reg < MAXC);
        cmd.shift     = |splits;
    end

    for (genvar g = 0; g < MAX_SEGMENTS; g++)
    begin : g_cell
        ffa_cell #(
            .HEADER_BYTES(HEADER_BYTES),
            .IS_FIRST    (g == 0),
            .RST_SIZE    (RST_SIZE)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .left    (links[g]),
            .right   (links[g+1]),
            .hit     (hits[g]),
            .split   (splits[g]),
            .res_addr(res_addrs[g])
        );
    end

    always_comb
    begin
        state_next    = state_reg;
        base_next     = base_reg;
        size_next     = size_reg;
        base_hdr_next = base_hdr_reg;
        count_next    = count_reg;
        kind_next     = kind_reg;
        req_next      = req_reg;
        req_hdr_next  = req_hdr_reg;
        addr_next     = addr_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        paddr_next    = paddr_reg;
        if (cfg_wr)
        begin
            count_next = CW'(1);
            if (cfg_index == ffa_pkg::CFG_HEAP_BASE)
            begin
                base_next     = cfg_data;
                base_hdr_next = cfg_data + HDR;
            end
            else
            begin
                size_next = cfg_data;
            end
        end
        case (state_reg)
            ffa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next   = ffa_pkg::S_SCAN;
                    kind_next    = ffa_pkg::kind_t'(kind);
                    req_next     = raised;
                    req_hdr_next = raised + HDR;
                    addr_next    = release_addr;
                end
            end
            ffa_pkg::S_SCAN:
            begin
                if (any_hit)
                begin
                    state_next  = ffa_pkg::S_IDLE;
                    done_next   = 1'b1;
                    status_next = ffa_pkg::ST_OK;
                    paddr_next  = res_or;
                    if (|splits)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                else if (links[MAX_SEGMENTS].tok)
                begin
                    state_next  = ffa_pkg::S_IDLE;
                    done_next   = 1'b1;
                    status_next = (kind_reg == ffa_pkg::KIND_FREE) ? ffa_pkg::ST_NOTFOUND
                                                                   : ffa_pkg::ST_OOM;
                    paddr_next  = 32'd0;
                end
            end
            default:
            begin
                state_next = ffa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ffa_pkg::S_IDLE;
            base_reg     <= 32'd0;
            size_reg     <= RST_HEAP[31:0];
            base_hdr_reg <= HDR;
            count_reg    <= CW'(1);
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            size_reg     <= size_next;
            base_hdr_reg <= base_hdr_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        req_reg     <= req_next;
        req_hdr_reg <= req_hdr_next;
        addr_reg    <= addr_next;
        status_reg  <= status_next;
        paddr_reg   <= paddr_next;
    end

    `FFA_ASSERT(a_hit_onehot, clk, rst_n, $onehot0(hits))
    `FFA_ASSERT(a_hit_in_scan, clk, rst_n, !any_hit || busy)
    `FFA_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy && !done)
    `FFA_ASSERT(a_count_bound, clk, rst_n, count_reg <= MAXC && count_reg != CW'(0))
    `FFA_ASSERT_NEXT(a_done_frees, clk, rst_n, busy && (any_hit || links[MAX_SEGMENTS].tok),
                     done && !busy)
endmodule
`default_nettype wire

### test/first_fit_block_allocator_tb.sv
// Testbench for first_fit_block_allocator: drives allocate and free commands and
// register writes, and checks every result against a first-fit table model.
// Depends on ffa_pkg and the first_fit_block_allocator RTL.
`timescale 1ns / 100ps
`default_nettype none
module first_fit_block_allocator_tb;
    localparam int NSEG = 64;
    localparam int HDR = 32;
    localparam int MINA = 128;

    class alloc_scoreboard;
        logic [31:0] base;
        logic [31:0] hsize;
        logic [31:0] offs [NSEG];
        logic [31:0] sizes [NSEG];
        bit frees [NSEG];
        int count;
        ffa_pkg::status_t want_st [$];
        logic [31:0] want_addr [$];
        int errors;
        int shown;
        logic [31:0] live [$];

        function void rebuild();
            for (int i = 0; i < NSEG; i++)
            begin
                offs[i] = 0;
                sizes[i] = 0;
                frees[i] = 0;
            end
            sizes[0] = (hsize >= HDR) ? hsize - HDR : 0;
            frees[0] = 1;
            count = 1;
            live.delete();
        endfunction

        function void write_reg(ffa_pkg::cfg_index_t idx, logic [31:0] v);
            if (idx == ffa_pkg::CFG_HEAP_BASE)
                base = v;
            else
                hsize = v;
            rebuild();
        endfunction

        function logic [31:0] addr_of(int i);
            return base + offs[i] + HDR;
        endfunction

        function void note_command(ffa_pkg::kind_t k, logic [31:0] rq, logic [31:0] ra);
            logic [31:0] req;
            logic [31:0] rem;
            if (k == ffa_pkg::KIND_ALLOC)
            begin
                req = (rq < MINA) ? MINA : rq;
                for (int i = 0; i < count; i++)
                begin
                    if (frees[i] && sizes[i] >= req)
                    begin
                        rem = sizes[i] - req;
                        if (rem >= HDR && count < NSEG)
                        begin
                            for (int j = count; j > i + 1; j--)
                            begin
                                offs[j] = offs[j-1];
                                sizes[j] = sizes[j-1];
                                frees[j] = frees[j-1];
                            end
                            offs[i+1] = offs[i] + HDR + req;
                            sizes[i+1] = rem - HDR;
                            frees[i+1] = 1;
                            count++;
                            sizes[i] = req;
                        end
                        frees[i] = 0;
                        want_st.push_back(ffa_pkg::ST_OK);
                        want_addr.push_back(addr_of(i));
                        live.push_back(addr_of(i));
                        return;
                    end
                end
                want_st.push_back(ffa_pkg::ST_OOM);
                want_addr.push_back(0);
            end
            else
            begin
                for (int i = 0; i < count; i++)
                begin
                    if (addr_of(i) == ra)
                    begin
                        frees[i] = 1;
                        want_st.push_back(ffa_pkg::ST_OK);
                        want_addr.push_back(0);
                        return;
                    end
                end
                want_st.push_back(ffa_pkg::ST_NOTFOUND);
                want_addr.push_back(0);
            end
        endfunction

        function void fail_one(string msg);
            errors++;
            if (shown < 10)
            begin
                shown++;
                $display("mismatch: %s", msg);
            end
        endfunction

        function void check_result(logic [1:0] st, logic [31:0] a);
            ffa_pkg::status_t es;
            logic [31:0] ea;
            if (want_st.size() == 0)
            begin
                fail_one($sformatf("unexpected result status %0d addr %h", st, a));
                return;
            end
            es = want_st.pop_front();
            ea = want_addr.pop_front();
            if (st !== es)
                fail_one($sformatf("status expected %0d actual %0d", es, st));
            if (a !== ea)
                fail_one($sformatf("payload_addr expected %h actual %h", ea, a));
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic kind = 0;
    logic [31:0] req_size = 0;
    logic [31:0] release_addr = 0;
    logic cfg_valid = 0;
    logic cfg_index = 0;
    logic [31:0] cfg_data = 0;
    wire busy;
    wire done;
    wire [1:0] status;
    wire [31:0] payload_addr;
    wire cfg_ready;
    bit calm = 0;

    alloc_scoreboard sb;

    always #5 clk = ~clk;

    first_fit_block_allocator DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .req_size(req_size), .release_addr(release_addr), .done(done),
        .status(status), .payload_addr(payload_addr), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always @(posedge clk)
        if (rst_n && done)
            sb.check_result(status, payload_addr);

    task automatic issue(ffa_pkg::kind_t k, logic [31:0] rq, logic [31:0] ra);
        @(posedge clk);
        if (!calm)
            while ($urandom_range(99) < 30)
                @(posedge clk);
        start <= 1;
        kind <= k;
        req_size <= rq;
        release_addr <= ra;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(k, rq, ra);
        start <= 0;
    endtask

    task automatic drain();
        while (sb.want_st.size() != 0)
            @(posedge clk);
        repeat (NSEG + 4)
            @(posedge clk);
    endtask

    task automatic write_cfg(ffa_pkg::cfg_index_t idx, logic [31:0] v);
        drain();
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, v);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return $urandom_range(127);
        if (r < 85)
            return $urandom_range(2000, 100);
        if (r < 95)
            return $urandom_range(40000, 2000);
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_addr();
        if (sb.live.size() != 0 && $urandom_range(99) < 80)
            return sb.live[$urandom_range(sb.live.size() - 1)];
        return $urandom;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            calm = (i >= n / 3 && i < n / 2);
            if ($urandom_range(99) < 55)
                issue(ffa_pkg::KIND_ALLOC, pick_size(), 0);
            else
                issue(ffa_pkg::KIND_FREE, $urandom, pick_addr());
        end
        calm = 0;
    endtask

    initial
    begin
        sb = new();
        sb.base = 0;
        sb.hsize = 65536;
        sb.rebuild();
        repeat (12)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        issue(ffa_pkg::KIND_ALLOC, 0, 0);
        issue(ffa_pkg::KIND_ALLOC, 128, 0);
        issue(ffa_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 0);
        issue(ffa_pkg::KIND_FREE, 0, 32);
        issue(ffa_pkg::KIND_FREE, 0, 32);
        issue(ffa_pkg::KIND_FREE, 0, 32'hFFFF_FFFF);
        issue(ffa_pkg::KIND_ALLOC, 100, 0);
        issue(ffa_pkg::KIND_ALLOC, 130, 0);
        issue(ffa_pkg::KIND_ALLOC, 65536 - 32 - 128 - 32 - 130 - 32 - 20, 0);
        issue(ffa_pkg::KIND_ALLOC, 128, 0);
        write_cfg(ffa_pkg::CFG_HEAP_SIZE, 16);
        issue(ffa_pkg::KIND_ALLOC, 0, 0);
        write_cfg(ffa_pkg::CFG_HEAP_BASE, 32'hFFFF_FFF0);
        write_cfg(ffa_pkg::CFG_HEAP_SIZE, 32'hFFFF_FFFF);
        issue(ffa_pkg::KIND_ALLOC, 200, 0);
        issue(ffa_pkg::KIND_FREE, 0, 32'h0000_0010);
        for (int i = 0; i < 66; i++)
            issue(ffa_pkg::KIND_ALLOC, 128, 0);
        drain();
        write_cfg(ffa_pkg::CFG_HEAP_BASE, 32'h1000_0000);
        write_cfg(ffa_pkg::CFG_HEAP_SIZE, 65536);
        random_phase(600);
        write_cfg(ffa_pkg::CFG_HEAP_BASE, $urandom);
        write_cfg(ffa_pkg::CFG_HEAP_SIZE, 8000);
        random_phase(500);
        write_cfg(ffa_pkg::CFG_HEAP_BASE, 32'hFFFF_FFFF);
        write_cfg(ffa_pkg::CFG_HEAP_SIZE, $urandom);
        random_phase(450);
        drain();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
